FILE: rtl/core/zfbw_pkg.sv
// Shared types and codes for the Zstandard frame and block walker.
`default_nettype none
package zfbw_pkg;

   localparam int OUT_POS_W = 48;

   typedef enum logic [1:0] {
      KIND_BLOCK = 2'd0,
      KIND_FRAME = 2'd1,
      KIND_SKIP  = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MAGIC     = 2'd1,
      ERR_BLOCKTYPE = 2'd2,
      ERR_HEADER    = 2'd3
   } err_type;

   typedef struct packed {
      kind_type               kind;
      err_type                code;
      logic [OUT_POS_W-1:0]   unit_offset;
      logic [OUT_POS_W-1:0]   unit_size;
      logic [OUT_POS_W-1:0]   body_offset;
      logic [OUT_POS_W-1:0]   body_size;
      logic                   stored;
      logic [63:0]            decoded_len;
      logic                   last_block;
      logic                   run_end;
   } event_type;

endpackage : zfbw_pkg
`default_nettype wire

FILE: rtl/core/zfbw_evq.sv
// Four-entry event queue between the byte parser and the result channel.
`default_nettype none
module zfbw_evq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [1:0]          push_n,
   input  wire zfbw_pkg::event_type push_ev0,
   input  wire zfbw_pkg::event_type push_ev1,
   output logic                     room,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output zfbw_pkg::event_type      head
);
   import zfbw_pkg::*;

   event_type  mem_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign room      = (count_ff <= 3'd2);
   assign head      = mem_ff[rp_ff];

   always_comb begin
      wp_in    = wp_ff + push_n;
      rp_in    = rp_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wp_ff] <= push_ev0;
      if (push_n == 2'd2) mem_ff[wp_ff + 2'd1] <= push_ev1;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4) else $error("event queue count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 |-> count_ff <= 3'd2) else $error("event queue overflow");
   a_push_limit: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd3) else $error("more than two events in one cycle");

endmodule : zfbw_evq
`default_nettype wire

FILE: rtl/core/zstd_frame_block_walker.sv
// Top level: byte-serial Zstandard frame, block and skippable-frame walker.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid/req_ready   | stream_byte
//   rsp     | out | rsp_valid/rsp_ready   | one event: kind, code, offsets, sizes, flags
//
// One byte is taken per cycle while req_ready is high; its parse is combinational
// and pushes into a four-entry event queue. A byte can emit up to two events
// (block then frame), so a stalled result side holds req_ready low once the queue
// has fewer than two free slots. Reset is synchronous and clears the parser and the
// queue; after an error event all bytes are taken and dropped until reset.
`default_nettype none
module zstd_frame_block_walker #(
   parameter int POS_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_event_kind,
   output logic [1:0]       rsp_error_code,
   output logic [47:0]      rsp_unit_offset,
   output logic [47:0]      rsp_unit_size,
   output logic [47:0]      rsp_body_offset,
   output logic [47:0]      rsp_body_size,
   output logic             rsp_stored_flag,
   output logic [63:0]      rsp_decoded_len,
   output logic             rsp_last_block,
   output logic             rsp_run_end
);
   import zfbw_pkg::*;

   typedef enum logic [2:0] {
      PH_MAGIC, PH_SKIPLEN, PH_DESC, PH_HDRREST, PH_BLKHDR
   } phase_type;

   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   phase_type           phase_ff, phase_in;
   logic [3:0]          fbc_ff, fbc_in;
   logic [63:0]         gather_ff, gather_in;
   logic [7:0]          desc_ff, desc_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [32:0]         skip_ff, skip_in;
   logic [POS_BITS-1:0] fstart_ff, fstart_in;
   logic                chk_ff, chk_in;
   logic [63:0]         fsize_ff, fsize_in;
   logic [POS_BITS-1:0] poff_ff, poff_in;
   logic [32:0]         psz_ff, psz_in;
   logic [20:0]         pcsz_ff, pcsz_in;
   logic                pvalid_ff, pvalid_in;
   logic                pskip_ff, pskip_in;
   logic                pstored_ff, pstored_in;
   logic                plast_ff, plast_in;
   logic                fowed_ff, fowed_in;
   logic                failed_ff, failed_in;

   logic       take;
   logic [1:0] push_n;
   event_type  ev0, ev1, head;
   logic       room;

   function automatic logic [3:0] fcs_len(input logic [7:0] d);
      logic [3:0] r;
      case (d[7:6])
         2'd0:    r = d[5] ? 4'd1 : 4'd0;
         2'd1:    r = 4'd2;
         2'd2:    r = 4'd4;
         2'd3:    r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   function automatic logic [47:0] to_out(input logic [POS_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[47:0];
   endfunction

   function automatic logic [63:0] put_byte(input logic [63:0] g, input logic [2:0] idx,
                                            input logic [7:0] b);
      logic [63:0] r;
      r = g;
      for (int i = 0; i < 8; i++) begin
         if (idx == 3'(i)) r[8*i +: 8] = g[8*i +: 8] | b;
      end
      return r;
   endfunction

   assign take      = req_valid && req_ready;
   assign req_ready = room;

   always_comb begin
      logic              drain;
      logic              err;
      err_type           ecode;
      logic [POS_BITS-1:0] ewhere;
      logic [3:0]        fl;
      logic [3:0]        rest;
      logic [23:0]       bh;
      logic [32:0]       wire_len;
      logic [POS_BITS:0] psum;
      logic [3:0]        hl;
      logic [1:0]        nidx;
      logic [POS_BITS-1:0] fsz;
      logic              do_finish;
      event_type         bev, fev;

      phase_in   = phase_ff;
      fbc_in     = fbc_ff;
      gather_in  = gather_ff;
      desc_in    = desc_ff;
      pos_in     = pos_ff;
      skip_in    = skip_ff;
      fstart_in  = fstart_ff;
      chk_in     = chk_ff;
      fsize_in   = fsize_ff;
      poff_in    = poff_ff;
      psz_in     = psz_ff;
      pcsz_in    = pcsz_ff;
      pvalid_in  = pvalid_ff;
      pskip_in   = pskip_ff;
      pstored_in = pstored_ff;
      plast_in   = plast_ff;
      fowed_in   = fowed_ff;
      failed_in  = failed_ff;
      drain      = 1'b0;
      err        = 1'b0;
      ecode      = ERR_NONE;
      ewhere     = '0;
      fl         = fcs_len(desc_ff);
      rest       = '0;
      bh         = '0;
      wire_len   = '0;
      do_finish  = 1'b0;

      if (take && !failed_ff) begin
         pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
         if (skip_ff != 33'd0) begin
            skip_in = skip_ff - 1'b1;
            drain   = (skip_in == 33'd0);
         end else begin
            case (phase_ff)
               PH_SKIPLEN: begin
                  gather_in = put_byte(gather_ff, {1'b0, fbc_ff[1:0]}, req_stream_byte);
                  fbc_in    = fbc_ff + 1'b1;
                  if (fbc_in == 4'd4) begin
                     poff_in    = fstart_ff;
                     psz_in     = {1'b0, gather_in[31:0]};
                     pcsz_in    = '0;
                     pvalid_in  = 1'b1;
                     pskip_in   = 1'b1;
                     pstored_in = 1'b1;
                     plast_in   = 1'b0;
                     skip_in    = {1'b0, gather_in[31:0]};
                     gather_in  = '0;
                     fbc_in     = '0;
                     phase_in   = PH_MAGIC;
                     drain      = (skip_in == 33'd0);
                  end
               end
               PH_DESC: begin
                  if (req_stream_byte[3]) begin
                     err    = 1'b1;
                     ecode  = ERR_HEADER;
                     ewhere = fstart_ff;
                  end else begin
                     desc_in   = req_stream_byte;
                     chk_in    = req_stream_byte[2];
                     fl        = fcs_len(req_stream_byte);
                     rest      = (req_stream_byte[5] ? 4'd0 : 4'd1)
                               + ((req_stream_byte[1:0] == 2'd3) ? 4'd4
                                                                 : {2'b00, req_stream_byte[1:0]})
                               + fl;
                     gather_in = '0;
                     fbc_in    = rest;
                     if (rest == 4'd0) do_finish = 1'b1;
                     else phase_in = PH_HDRREST;
                  end
               end
               PH_HDRREST: begin
                  if (fbc_ff != 4'd0 && fbc_ff <= fl) begin
                     gather_in = put_byte(gather_ff, 3'(fl - fbc_ff), req_stream_byte);
                  end
                  fbc_in = (fbc_ff != 4'd0) ? fbc_ff - 1'b1 : 4'd0;
                  if (fbc_in == 4'd0) do_finish = 1'b1;
               end
               PH_BLKHDR: begin
                  if (fbc_ff == 4'd0) poff_in = pos_ff;
                  gather_in = put_byte(gather_ff, {1'b0, fbc_ff[1:0]}, req_stream_byte);
                  fbc_in    = fbc_ff + 1'b1;
                  if (fbc_in == 4'd3) begin
                     bh        = gather_in[23:0];
                     gather_in = '0;
                     fbc_in    = '0;
                     if (bh[2:1] == 2'd3) begin
                        err    = 1'b1;
                        ecode  = ERR_BLOCKTYPE;
                        ewhere = poff_ff;
                     end else begin
                        wire_len   = (bh[2:1] == 2'd1) ? 33'd1 : 33'(bh[23:3]);
                        psz_in     = wire_len;
                        pcsz_in    = (bh[2:1] == 2'd2) ? 21'd0 : bh[23:3];
                        pvalid_in  = 1'b1;
                        pskip_in   = 1'b0;
                        pstored_in = (bh[2:1] == 2'd0);
                        plast_in   = bh[0];
                        skip_in    = wire_len;
                        if (bh[0]) begin
                           if (chk_ff) skip_in = wire_len + 33'd4;
                           fowed_in = 1'b1;
                           phase_in = PH_MAGIC;
                        end
                        drain = (skip_in == 33'd0);
                     end
                  end
               end
               default: begin
                  if (fbc_ff == 4'd0) begin
                     fstart_in = pos_ff;
                     gather_in = '0;
                  end
                  phase_in  = PH_MAGIC;
                  gather_in = put_byte(gather_in, {1'b0, fbc_ff[1:0]}, req_stream_byte);
                  fbc_in    = fbc_ff + 1'b1;
                  if (fbc_in == 4'd4) begin
                     fbc_in = '0;
                     if (gather_in[31:4] == 28'h184D2A5) begin
                        phase_in = PH_SKIPLEN;
                     end else if (gather_in[31:0] != 32'hFD2FB528) begin
                        err    = 1'b1;
                        ecode  = ERR_MAGIC;
                        ewhere = fstart_in;
                     end else begin
                        phase_in = PH_DESC;
                     end
                     gather_in = '0;
                  end
               end
            endcase
         end
      end

      if (do_finish) begin
         case (fl)
            4'd0:    fsize_in = '0;
            4'd2:    fsize_in = gather_in + 64'd256;
            default: fsize_in = gather_in;
         endcase
         gather_in = '0;
         fbc_in    = '0;
         phase_in  = PH_BLKHDR;
      end

      // block event from the pending slot
      hl   = pskip_in ? 4'd8 : 4'd3;
      psum = {1'b0, poff_in} + (POS_BITS+1)'(hl);
      bev                = '0;
      bev.kind           = pskip_in ? KIND_SKIP : KIND_BLOCK;
      bev.code           = ERR_NONE;
      bev.unit_offset    = to_out(poff_in);
      bev.unit_size      = 48'(psz_in) + 48'(hl);
      bev.body_offset    = psum[POS_BITS] ? to_out(POS_MAX) : to_out(psum[POS_BITS-1:0]);
      bev.body_size      = 48'(psz_in);
      bev.stored         = pstored_in;
      bev.decoded_len    = 64'(pcsz_in);
      bev.last_block     = plast_in;

      fsz                = pos_in - fstart_in;
      fev                = '0;
      fev.kind           = KIND_FRAME;
      fev.code           = ERR_NONE;
      fev.unit_offset    = to_out(fstart_in);
      fev.unit_size      = to_out(fsz);
      fev.body_offset    = to_out(fstart_in);
      fev.body_size      = to_out(fsz);
      fev.decoded_len    = fsize_in;

      ev0    = '0;
      ev1    = '0;
      push_n = 2'd0;
      nidx   = 2'd0;
      if (err) begin
         failed_in      = 1'b1;
         ev0.kind       = KIND_ERROR;
         ev0.code       = ecode;
         ev0.unit_offset = to_out(ewhere);
         ev0.run_end    = 1'b1;
         push_n         = 2'd1;
      end else if (drain) begin
         if (pvalid_in) begin
            ev0       = bev;
            ev0.run_end = !fowed_in;
            nidx      = 2'd1;
            pvalid_in = 1'b0;
         end
         if (fowed_in) begin
            if (nidx == 2'd0) begin
               ev0 = fev;
               ev0.run_end = 1'b1;
            end else begin
               ev1 = fev;
               ev1.run_end = 1'b1;
            end
            nidx     = nidx + 2'd1;
            fowed_in = 1'b0;
         end
         push_n = nidx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC;
         fbc_ff     <= '0;
         gather_ff  <= '0;
         desc_ff    <= '0;
         pos_ff     <= '0;
         skip_ff    <= '0;
         fstart_ff  <= '0;
         chk_ff     <= 1'b0;
         fsize_ff   <= '0;
         poff_ff    <= '0;
         psz_ff     <= '0;
         pcsz_ff    <= '0;
         pvalid_ff  <= 1'b0;
         pskip_ff   <= 1'b0;
         pstored_ff <= 1'b0;
         plast_ff   <= 1'b0;
         fowed_ff   <= 1'b0;
         failed_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         fbc_ff     <= fbc_in;
         gather_ff  <= gather_in;
         desc_ff    <= desc_in;
         pos_ff     <= pos_in;
         skip_ff    <= skip_in;
         fstart_ff  <= fstart_in;
         chk_ff     <= chk_in;
         fsize_ff   <= fsize_in;
         poff_ff    <= poff_in;
         psz_ff     <= psz_in;
         pcsz_ff    <= pcsz_in;
         pvalid_ff  <= pvalid_in;
         pskip_ff   <= pskip_in;
         pstored_ff <= pstored_in;
         plast_ff   <= plast_in;
         fowed_ff   <= fowed_in;
         failed_ff  <= failed_in;
      end
   end

   zfbw_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push_ev0  (ev0),
      .push_ev1  (ev1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_event_kind     = head.kind;
   assign rsp_error_code     = head.code;
   assign rsp_unit_offset    = head.unit_offset;
   assign rsp_unit_size      = head.unit_size;
   assign rsp_body_offset    = head.body_offset;
   assign rsp_body_size      = head.body_size;
   assign rsp_stored_flag    = head.stored;
   assign rsp_decoded_len    = head.decoded_len;
   assign rsp_last_block     = head.last_block;
   assign rsp_run_end        = head.run_end;

   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff) else $error("error state left without reset");
   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> push_n == 2'd0 && skip_ff == 33'd0) else $error("events after error");
   a_pos_frozen: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> $stable(pos_ff)) else $error("position moved after error");

endmodule : zstd_frame_block_walker
`default_nettype wire

FILE: tb/sv/tb_zstd_frame_block_walker.sv
// Self-checking testbench for the Zstandard frame and block walker.
`timescale 1ns / 100ps
`default_nettype none
module tb_zstd_frame_block_walker;
   import zfbw_pkg::*;

   localparam int          WATCHDOG_LIMIT = 20000;
   localparam logic [47:0] POS_LIMIT      = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] FRAME_MAGIC    = 32'hFD2F_B528;
   localparam logic [31:0] SKIP_MAGIC     = 32'h184D_2A50;

   typedef enum logic [2:0] {
      WALK_MAGIC, WALK_SKIPLEN, WALK_DESC, WALK_HDRREST, WALK_BLKHDR
   } walk_state_type;

   typedef enum int {FAIL_MAGIC, FAIL_HEADER, FAIL_BLOCKTYPE} fail_pick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [1:0]  rsp_error_code;
   logic [47:0] rsp_unit_offset;
   logic [47:0] rsp_unit_size;
   logic [47:0] rsp_body_offset;
   logic [47:0] rsp_body_size;
   logic        rsp_stored_flag;
   logic [63:0] rsp_decoded_len;
   logic        rsp_last_block;
   logic        rsp_run_end;

   zstd_frame_block_walker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_event_kind(rsp_event_kind), .rsp_error_code(rsp_error_code),
      .rsp_unit_offset(rsp_unit_offset), .rsp_unit_size(rsp_unit_size),
      .rsp_body_offset(rsp_body_offset), .rsp_body_size(rsp_body_size),
      .rsp_stored_flag(rsp_stored_flag), .rsp_decoded_len(rsp_decoded_len),
      .rsp_last_block(rsp_last_block), .rsp_run_end(rsp_run_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic [7:0]  stream_q[$];
   event_type   events_due[$];
   int          sender_idle_pct = 37;
   int          receiver_idle_pct = 72;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   // walker model state
   walk_state_type w_state = WALK_MAGIC;
   logic [3:0]  w_count = '0;
   logic [63:0] w_gather = '0;
   logic [7:0]  w_desc = '0;
   logic [47:0] w_pos = '0;
   logic [32:0] w_skip = '0;
   logic [47:0] w_frame_start = '0;
   logic        w_checksum = 1'b0;
   logic [63:0] w_frame_content = '0;
   logic [47:0] pend_offset = '0;
   logic [47:0] pend_payload = '0;
   logic [63:0] pend_content = '0;
   logic        pend_valid = 1'b0;
   kind_type    pend_kind = KIND_BLOCK;
   logic        pend_stored = 1'b0;
   logic        pend_last = 1'b0;
   logic        w_frame_owed = 1'b0;
   logic        w_failed = 1'b0;

   function automatic logic [47:0] pos_add(logic [47:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {17'd0, a} + {1'b0, b};
      return (s > {17'd0, POS_LIMIT}) ? POS_LIMIT : s[47:0];
   endfunction

   function automatic int fcs_bytes(logic [7:0] d);
      if (d[7:6] == 2'd0) return d[5] ? 1 : 0;
      return 1 << d[7:6];
   endfunction

   function automatic void post_event(kind_type k, err_type c, logic [47:0] uoff,
                                      logic [47:0] usz, logic [47:0] poff,
                                      logic [47:0] psz, logic st, logic [63:0] csz,
                                      logic lst);
      event_type e;
      e.kind = k; e.code = c; e.unit_offset = uoff; e.unit_size = usz;
      e.body_offset = poff; e.body_size = psz; e.stored = st;
      e.decoded_len = csz; e.last_block = lst; e.run_end = 1'b0;
      events_due.push_back(e);
   endfunction

   // block or skippable event first, then the frame event
   function automatic void release_owed();
      int n;
      logic [47:0] hl;
      logic [47:0] fsz;
      n = 0;
      if (pend_valid) begin
         hl = (pend_kind == KIND_SKIP) ? 48'd8 : 48'd3;
         post_event(pend_kind, ERR_NONE, pend_offset, hl + pend_payload,
                    pos_add(pend_offset, hl), pend_payload, pend_stored,
                    pend_content, pend_last);
         pend_valid = 1'b0;
         n++;
      end
      if (w_frame_owed) begin
         fsz = w_pos - w_frame_start;
         post_event(KIND_FRAME, ERR_NONE, w_frame_start, fsz, w_frame_start, fsz,
                    1'b0, w_frame_content, 1'b0);
         w_frame_owed = 1'b0;
         n++;
      end
      if (n > 0) events_due[$].run_end = 1'b1;
   endfunction

   function automatic void raise_error(err_type c, logic [47:0] at);
      w_failed = 1'b1;
      post_event(KIND_ERROR, c, at, '0, '0, '0, 1'b0, '0, 1'b0);
      events_due[$].run_end = 1'b1;
   endfunction

   function automatic void close_header();
      int fl;
      fl = fcs_bytes(w_desc);
      if (fl == 0) w_frame_content = '0;
      else if (fl == 2) w_frame_content = w_gather + 64'd256;
      else w_frame_content = w_gather;
      w_gather = '0;
      w_count = '0;
      w_state = WALK_BLKHDR;
   endfunction

   function automatic void walk_byte(logic [7:0] b);
      logic [47:0] cur;
      logic [23:0] bh;
      logic [1:0]  btype;
      logic [63:0] wire_len;
      int rest, fl, left;
      if (w_failed) return;
      cur = w_pos;
      w_pos = pos_add(cur, 64'd1);
      if (w_skip != 0) begin
         w_skip = w_skip - 1;
         if (w_skip == 0) release_owed();
         return;
      end
      case (w_state)
         WALK_SKIPLEN: begin
            w_gather |= 64'(b) << (8 * w_count[1:0]);
            w_count++;
            if (w_count < 4) return;
            pend_offset = w_frame_start;
            pend_payload = {16'd0, w_gather[31:0]};
            pend_content = '0;
            pend_valid = 1'b1; pend_kind = KIND_SKIP; pend_stored = 1'b1; pend_last = 1'b0;
            w_skip = {1'b0, w_gather[31:0]};
            w_gather = '0; w_count = '0; w_state = WALK_MAGIC;
            if (w_skip == 0) release_owed();
         end
         WALK_DESC: begin
            if (b[3]) begin
               raise_error(ERR_HEADER, w_frame_start);
               return;
            end
            w_desc = b;
            w_checksum = b[2];
            rest = (b[5] ? 0 : 1) + (b[1:0] == 2'd3 ? 4 : int'(b[1:0])) + fcs_bytes(b);
            w_gather = '0;
            w_count = rest[3:0];
            if (rest == 0) close_header();
            else w_state = WALK_HDRREST;
         end
         WALK_HDRREST: begin
            fl = fcs_bytes(w_desc);
            left = w_count;
            if (left != 0 && left <= fl) w_gather |= 64'(b) << (8 * ((fl - left) & 7));
            w_count = (left > 0) ? 4'(left - 1) : 4'd0;
            if (w_count == 0) close_header();
         end
         WALK_BLKHDR: begin
            if (w_count == 0) pend_offset = cur;
            w_gather |= 64'(b) << (8 * w_count[1:0]);
            w_count++;
            if (w_count < 3) return;
            bh = w_gather[23:0];
            w_gather = '0; w_count = '0;
            btype = bh[2:1];
            if (btype == 2'd3) begin
               raise_error(ERR_BLOCKTYPE, pend_offset);
               return;
            end
            wire_len = (btype == 2'd1) ? 64'd1 : 64'(bh[23:3]);
            pend_payload = wire_len[47:0];
            pend_content = (btype == 2'd2) ? 64'd0 : 64'(bh[23:3]);
            pend_valid = 1'b1; pend_kind = KIND_BLOCK;
            pend_stored = (btype == 2'd0); pend_last = bh[0];
            w_skip = wire_len[32:0];
            if (bh[0]) begin
               if (w_checksum) w_skip += 33'd4;
               w_frame_owed = 1'b1;
               w_state = WALK_MAGIC;
            end
            if (w_skip == 0) release_owed();
         end
         default: begin
            if (w_count == 0) begin
               w_frame_start = cur;
               w_gather = '0;
            end
            w_state = WALK_MAGIC;
            w_gather |= 64'(b) << (8 * w_count[1:0]);
            w_count++;
            if (w_count < 4) return;
            w_count = '0;
            if (w_gather[31:4] == SKIP_MAGIC[31:4]) begin
               w_state = WALK_SKIPLEN;
               w_gather = '0;
            end else if (w_gather[31:0] != FRAME_MAGIC) begin
               w_gather = '0;
               raise_error(ERR_MAGIC, w_frame_start);
            end else begin
               w_gather = '0;
               w_state = WALK_DESC;
            end
         end
      endcase
   endfunction

   // ---------------- stream builders
   task automatic put_le(logic [63:0] v, int n);
      for (int i = 0; i < n; i++) stream_q.push_back(v[8*i +: 8]);
   endtask

   task automatic put_random(int n);
      for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom));
   endtask

   task automatic put_block(logic lst, logic [1:0] btype, logic [20:0] bsize);
      put_le({bsize, btype, lst}, 3);
      if (btype == 2'd1) put_random(1);
      else put_random(bsize);
   endtask

   task automatic put_frame();
      logic [7:0] d;
      int nblk;
      logic [1:0] bt;
      d = 8'($urandom);
      d[3] = 1'b0;
      put_le(FRAME_MAGIC, 4);
      stream_q.push_back(d);
      put_random((d[5] ? 0 : 1) + (d[1:0] == 2'd3 ? 4 : d[1:0]) + fcs_bytes(d));
      nblk = $urandom_range(1, 4);
      for (int i = 0; i < nblk; i++) begin
         bt = 2'($urandom_range(0, 2));
         if (bt == 2'd1) put_block(i == nblk - 1, bt, 21'($urandom));
         else put_block(i == nblk - 1, bt, 21'($urandom_range(0, 7)));
      end
      if (d[2]) put_random(4);
   endtask

   task automatic put_skippable();
      logic [31:0] len;
      len = $urandom_range(0, 6);
      put_le(SKIP_MAGIC | 32'($urandom_range(0, 15)), 4);
      put_le(len, 4);
      put_random(len);
   endtask

   task automatic wait_fed();
      while (stream_q.size() != 0 || req_valid) @(posedge clock);
   endtask

   task automatic run_random(int sidle, int ridle, int nbytes);
      sender_idle_pct = sidle;
      receiver_idle_pct = ridle;
      while (stream_q.size() < nbytes) begin
         if ($urandom_range(0, 4) == 0) put_skippable();
         else put_frame();
      end
      wait_fed();
   endtask

   initial begin
      fail_pick_type pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed: 1-byte content size, empty raw block, RLE with the widest size
      // field, checksum after the last block, then an empty skippable frame
      put_le(FRAME_MAGIC, 4);
      stream_q.push_back(8'h24);
      stream_q.push_back(8'hFF);
      put_block(1'b0, 2'd0, 21'd0);
      put_block(1'b1, 2'd1, 21'h1F_FFFF);
      put_random(4);
      put_le(SKIP_MAGIC | 32'hF, 4);
      put_le(32'd0, 4);
      wait_fed();
      // hold the sender until the directed results are all out
      while (events_due.size() != 0) @(posedge clock);
      run_random(37, 72, 500);
      run_random(72, 37, 500);
      run_random(0, 0, 500);
      // finish with one fatal stream error, then bytes that must be dropped
      pick = fail_pick_type'($urandom_range(0, 2));
      case (pick)
         FAIL_MAGIC: begin
            put_le(32'h0000_0000 | 32'($urandom_range(0, 255)), 4);
         end
         FAIL_HEADER: begin
            put_le(FRAME_MAGIC, 4);
            stream_q.push_back(8'($urandom) | 8'h08);
         end
         default: begin
            put_le(FRAME_MAGIC, 4);
            stream_q.push_back(8'h20);
            put_random(1);
            put_le({21'($urandom), 2'd3, 1'($urandom)}, 3);
         end
      endcase
      put_random(20);
      wait_fed();
      while (events_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // ---------------- byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (stream_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_stream_byte <= stream_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------- monitor and watchdog
   always @(posedge clock) begin
      event_type e;
      if (!reset) begin
         if (req_valid && req_ready) walk_byte(req_stream_byte);
         if (rsp_valid && rsp_ready) begin
            if (events_due.size() == 0) begin
               $error("event with none due: kind %0d offset %0h",
                      rsp_event_kind, rsp_unit_offset);
               mismatches++;
            end else begin
               e = events_due.pop_front();
               check_field("event_kind", e.kind, rsp_event_kind);
               check_field("error_code", e.code, rsp_error_code);
               check_field("unit_offset", e.unit_offset, rsp_unit_offset);
               check_field("unit_size", e.unit_size, rsp_unit_size);
               check_field("body_offset", e.body_offset, rsp_body_offset);
               check_field("body_size", e.body_size, rsp_body_size);
               check_field("stored_flag", e.stored, rsp_stored_flag);
               check_field("decoded_len", e.decoded_len, rsp_decoded_len);
               check_field("last_block", e.last_block, rsp_last_block);
               check_field("run_end", e.run_end, rsp_run_end);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
